FILE: hw/rtl/ebs_pkg.sv
// Shared constants, codes and controller/datapath interface types for energy_bin_search.
`default_nettype none

package ebs_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 1024;

	localparam int unsigned ENERGY_W = 32;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned CFG_W    = 11;
	localparam int unsigned BIN_W    = 10;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// read address select
	localparam logic [1:0] RDS_LAST  = 2'd0;
	localparam logic [1:0] RDS_FIRST = 2'd1;
	localparam logic [1:0] RDS_SPAN  = 2'd2;
	localparam logic [1:0] RDS_NEXT  = 2'd3;

	// result select
	localparam logic [1:0] RES_LAST  = 2'd0;
	localparam logic [1:0] RES_ZERO  = 2'd1;
	localparam logic [1:0] RES_LO    = 2'd2;
	localparam logic [1:0] RES_FINAL = 2'd3;

	typedef struct packed {
		logic       wr_en;
		logic       search_ld;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       mid_ld;
		logic       step_upd;
		logic       res_ld;
		logic [1:0] res_sel;
		logic       out_ld;
	} ebs_cmd_t;

	typedef struct packed {
		logic e_lt;       // energy below probed edge
		logic e_gt;       // energy above probed edge
		logic span_zero;  // hi == lo
		logic span_one;   // hi - lo == 1
		logic next_one;   // span after this step is one
	} ebs_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ebs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module ebs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ebs_ctrl.sv
// Sequencer for table writes, boundary checks and bisection of a search.
`default_nettype none

module ebs_ctrl import ebs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        func,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	input  wire ebs_status_t status,
	output ebs_cmd_t         cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LAST  = 3'd1;
	localparam logic [2:0] S_FIRST = 3'd2;
	localparam logic [2:0] S_STEP  = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (func == FUNC_SEARCH) begin
						cmd.search_ld = 1'b1;
						cmd.rd_en     = 1'b1;
						cmd.rd_sel    = RDS_LAST;
						state_d       = S_LAST;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			S_LAST: begin
				if (status.e_lt) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_LAST;
					state_d     = S_OUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RDS_FIRST;
					state_d    = S_FIRST;
				end
			end
			S_FIRST: begin
				if (status.e_gt) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_ZERO;
					state_d     = S_OUT;
				end else if (status.span_zero) begin
					// single-entry table
					cmd.res_ld  = 1'b1;
					cmd.res_sel = RES_LO;
					state_d     = S_OUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RDS_SPAN;
					cmd.mid_ld = 1'b1;
					state_d    = status.span_one ? S_FINAL : S_STEP;
				end
			end
			S_STEP: begin
				cmd.step_upd = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = RDS_NEXT;
				state_d      = status.next_one ? S_FINAL : S_STEP;
			end
			S_FINAL: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = RES_FINAL;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ebs_dp.sv
// Datapath: edge table, entry count, search span registers and result register.
`default_nettype none

module ebs_dp import ebs_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_wdata,
	input  wire logic [INDEX_W-1:0]  entry_index,
	input  wire logic [ENERGY_W-1:0] energy_value,
	input  wire ebs_cmd_t            cmd,
	output ebs_status_t              status,
	output logic [BIN_W-1:0]         bin_index
);

	localparam int unsigned AW = $clog2(TABLE_ENTRIES);

	logic [AW-1:0]       last_idx_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [AW-1:0]       lo_q, hi_q, mid_q;
	logic [AW-1:0]       result_q;
	logic [BIN_W-1:0]    bin_index_q;

	logic [31:0]         cfg_n;
	logic                wr_ok;
	logic [AW-1:0]       rd_addr;
	logic [ENERGY_W-1:0] rd_data;

	logic [AW-1:0] span, mid_cur;
	logic [AW-1:0] da, db, mid_a, mid_b;
	logic          a_one, b_one;
	logic [AW-1:0] next_mid, next_addr;

	// clamp the entry count into 1..TABLE_ENTRIES
	always_comb begin
		cfg_n = 32'(cfg_wdata);
		if (cfg_n == 32'd0) begin
			cfg_n = 32'd1;
		end else if (cfg_n > TABLE_ENTRIES) begin
			cfg_n = TABLE_ENTRIES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= '0;
		end else if (cfg_we) begin
			last_idx_q <= AW'(cfg_n - 32'd1);
		end
	end

	assign wr_ok = (32'(entry_index) < TABLE_ENTRIES);

	// span arithmetic from registered bounds, in parallel with the table read
	assign span    = hi_q - lo_q;
	assign mid_cur = lo_q + (span >> 1);
	assign da      = hi_q - mid_q;
	assign db      = mid_q - lo_q;
	assign a_one   = (da == AW'(1));
	assign b_one   = (db == AW'(1));
	assign mid_a   = mid_q + (da >> 1);
	assign mid_b   = lo_q + (db >> 1);

	// edge[mid] above energy moves lo up to mid
	assign next_mid  = status.e_lt ? mid_a : mid_b;
	assign next_addr = status.e_lt ? (a_one ? hi_q : mid_a) : (b_one ? mid_q : mid_b);

	always_comb begin
		case (cmd.rd_sel)
			RDS_LAST:  rd_addr = last_idx_q;
			RDS_FIRST: rd_addr = '0;
			RDS_SPAN:  rd_addr = status.span_one ? hi_q : mid_cur;
			RDS_NEXT:  rd_addr = next_addr;
			default:   rd_addr = '0;
		endcase
	end

	ebs_ram #(
		.WIDTH(ENERGY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_en && wr_ok),
		.waddr(AW'(entry_index)),
		.wdata(energy_value),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign status.e_lt      = (energy_q < rd_data);
	assign status.e_gt      = (energy_q > rd_data);
	assign status.span_zero = (span == '0);
	assign status.span_one  = (span == AW'(1));
	assign status.next_one  = status.e_lt ? a_one : b_one;

	always_ff @(posedge clk) begin
		if (cmd.search_ld) begin
			energy_q <= energy_value;
			lo_q     <= '0;
			hi_q     <= last_idx_q;
		end
		if (cmd.mid_ld) begin
			mid_q <= mid_cur;
		end
		if (cmd.step_upd) begin
			if (status.e_lt) begin
				lo_q <= mid_q;
			end else begin
				hi_q <= mid_q;
			end
			mid_q <= next_mid;
		end
		if (cmd.res_ld) begin
			case (cmd.res_sel)
				RES_LAST:  result_q <= last_idx_q;
				RES_ZERO:  result_q <= '0;
				RES_LO:    result_q <= lo_q;
				RES_FINAL: result_q <= status.e_lt ? lo_q : hi_q;
				default:   result_q <= lo_q;
			endcase
		end
		if (cmd.out_ld) begin
			bin_index_q <= BIN_W'(result_q);
		end
	end

	assign bin_index = bin_index_q;

endmodule

`default_nettype wire

FILE: hw/rtl/energy_bin_search_top.sv
// Top level of energy_bin_search: bin lookup in a decreasing table of edges.
//
//  channel  handshake              payload
//  req      req_valid / req_stall  func, entry_index, energy_value
//  rsp      rsp_valid / rsp_stall  bin_index
//  cfg      cfg_we                 cfg_wdata (entries_in_use)
//
// A write transaction is accepted in S_IDLE without leaving it. A search probes the
// last and first edges, then bisects; it ends early when an end edge decides it, and
// every table probe goes through the single registered read port.
// Reset clears control and sets the entry count to one; table contents stay
// undefined until written. req_stall is high from search acceptance until the
// result sits in the output register; a stalled rsp holds the next search there.
`default_nettype none

module energy_bin_search_top import ebs_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_W-1:0]    cfg_wdata,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic                func,
	input  wire logic [INDEX_W-1:0]  entry_index,
	input  wire logic [ENERGY_W-1:0] energy_value,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [BIN_W-1:0]         bin_index
);

	ebs_cmd_t    cmd;
	ebs_status_t status;

	ebs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func     (func),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ebs_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.entry_index (entry_index),
		.energy_value(energy_value),
		.cmd         (cmd),
		.status      (status),
		.bin_index   (bin_index)
	);

endmodule

`default_nettype wire

FILE: bench/energy_bin_search_checker.sv
// Checker for energy_bin_search_top: tracks the edge table, predicts bin indexes, compares results.
module energy_bin_search_checker import ebs_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                req_valid,
	input  logic                req_stall,
	input  logic                func,
	input  logic [INDEX_W-1:0]  entry_index,
	input  logic [ENERGY_W-1:0] energy_value,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  logic [BIN_W-1:0]    bin_index,
	output int unsigned         failures,
	output int unsigned         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [ENERGY_W-1:0] lower_edges [TABLE_ENTRIES];
	logic [CFG_W-1:0]    entries_cfg;
	logic [BIN_W-1:0]    expected_bins [$];
	logic [BIN_W-1:0]    want;
	int unsigned         fail_count = 0;

	initial begin
		failures = 0;
		outstanding = 0;
		entries_cfg = 1;
	end

	// bisection over the edges in use; the table is meant to fall as the index rises
	function automatic logic [BIN_W-1:0] locate_bin(input logic [ENERGY_W-1:0] e);
		int unsigned n;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		if (entries_cfg == 0)
			n = 1;
		else if (entries_cfg > TABLE_ENTRIES)
			n = TABLE_ENTRIES;
		else
			n = entries_cfg;
		lo = 0;
		hi = n - 1;
		if (e < lower_edges[n-1])
			return BIN_W'(n - 1);
		if (e > lower_edges[0])
			return '0;
		while (hi > lo) begin
			if (hi - lo == 1)
				return (lower_edges[hi] <= e) ? BIN_W'(hi) : BIN_W'(lo);
			mid = lo + (hi - lo) / 2;
			if (lower_edges[mid] > e)
				lo = mid;
			else
				hi = mid;
		end
		return BIN_W'(lo);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			entries_cfg = 1;
			expected_bins.delete();
		end else begin
			if (cfg_we)
				entries_cfg = cfg_wdata;
			if (rsp_valid && !rsp_stall) begin
				if (expected_bins.size() == 0) begin
					fail_count++;
					$error("bin_index: no search outstanding, got %0d", bin_index);
				end else begin
					want = expected_bins.pop_front();
					if (bin_index !== want) begin
						fail_count++;
						$error("bin_index: expected %0d, got %0d", want, bin_index);
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (func == FUNC_WRITE) begin
					if (entry_index < TABLE_ENTRIES)
						lower_edges[entry_index] = energy_value;
				end else begin
					expected_bins.push_back(locate_bin(energy_value));
				end
			end
		end
		failures <= fail_count;
		outstanding <= expected_bins.size();
	end

endmodule

FILE: bench/testbench.sv
// Testbench top for energy_bin_search_top: clock, reset, stimulus, back-pressure and verdict.
module testbench;
	import ebs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ITEM_TARGET     = 1650;
	localparam int unsigned SETTLE_CYCLES   = 20;
	localparam int unsigned RSP_HOLD_CYCLES = 200;
	localparam int unsigned WATCHDOG_LIMIT  = 5000;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                req_valid;
	logic                req_stall;
	logic                func;
	logic [INDEX_W-1:0]  entry_index;
	logic [ENERGY_W-1:0] energy_value;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [BIN_W-1:0]    bin_index;

	int unsigned failures;
	int unsigned outstanding;
	int unsigned items_sent = 0;
	int unsigned hold_requests = 0;
	int unsigned used_n = 1;
	idle_mode_t  idle_mode = IDLE_NONE;

	// stimulus-side copy of the table, only used to aim query energies
	logic [ENERGY_W-1:0] shadow_edges [TABLE_ENTRIES_DEF];
	bit                  written [TABLE_ENTRIES_DEF];

	energy_bin_search_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.entry_index  (entry_index),
		.energy_value (energy_value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.bin_index    (bin_index)
	);

	energy_bin_search_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.entry_index  (entry_index),
		.energy_value (energy_value),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.bin_index    (bin_index),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("FAIL energy_bin_search_top");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off per request from the stimulus
	initial begin
		int unsigned holds_done;
		holds_done = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				rsp_stall <= 1'b1;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < ((idle_mode == IDLE_RECEIVER) ? 73 :
				(idle_mode == IDLE_BOTH) ? 30 : 0));
		end
	end

	// valid is held, payload steady, until the transaction is taken
	task automatic offer_request(input logic f, input logic [INDEX_W-1:0] idx,
			input logic [ENERGY_W-1:0] e);
		while ($urandom_range(99) < ((idle_mode == IDLE_SENDER) ? 73 :
				(idle_mode == IDLE_BOTH) ? 30 : 0)) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		entry_index <= idx;
		energy_value <= e;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_write(input int unsigned idx, input logic [ENERGY_W-1:0] v);
		shadow_edges[idx] = v;
		written[idx] = 1'b1;
		offer_request(FUNC_WRITE, INDEX_W'(idx), v);
	endtask

	task automatic send_search(input logic [ENERGY_W-1:0] e);
		offer_request(FUNC_SEARCH, INDEX_W'($urandom), e);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		// a trailing table write leaves no result behind, give it time to land
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [CFG_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (v == 0)
			used_n = 1;
		else if (v > TABLE_ENTRIES_DEF)
			used_n = TABLE_ENTRIES_DEF;
		else
			used_n = v;
	endtask

	initial begin
		int unsigned         phase;
		int unsigned         burst;
		int unsigned         style;
		int unsigned         stepmax;
		int unsigned         k;
		int unsigned         i;
		bit                  pressure;
		logic [CFG_W-1:0]    cfg_val;
		logic [ENERGY_W-1:0] level;
		logic [ENERGY_W-1:0] probe;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_valid <= 1'b0;
		func <= FUNC_WRITE;
		entry_index <= '0;
		energy_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-entry table straight out of reset: both ends and an exact hit
		send_write(0, 32'h8000_0000);
		send_write(TABLE_ENTRIES_DEF - 1, 32'hFFFF_FFFF);
		send_search(32'h0000_0000);
		send_search(32'hFFFF_FFFF);
		send_search(32'h8000_0000);
		// zero entries in use behaves as one
		reconfigure('0);
		send_search(32'h8000_0001);
		send_search(32'h7FFF_FFFF);
		reconfigure(CFG_W'(4));
		send_write(0, 32'd400);
		send_write(1, 32'd300);
		send_write(2, 32'd200);
		send_write(3, 32'd100);
		send_search(32'd50);
		send_search(32'd500);
		send_search(32'd400);
		send_search(32'd300);
		send_search(32'd250);
		send_search(32'd100);
		send_search(32'd150);
		// span of one from the start
		reconfigure(CFG_W'(2));
		send_search(32'd350);
		send_search(32'd300);
		send_search(32'd299);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase == 3)
				cfg_val = CFG_W'(TABLE_ENTRIES_DEF);
			else if (phase == 8)
				cfg_val = '1;
			else if (phase % 10 == 6)
				cfg_val = '0;
			else if (phase % 10 == 9)
				cfg_val = CFG_W'($urandom_range(2047, TABLE_ENTRIES_DEF + 1));
			else if (phase % 10 == 4)
				cfg_val = CFG_W'($urandom_range(TABLE_ENTRIES_DEF, 65));
			else
				cfg_val = CFG_W'($urandom_range(48, 1));
			reconfigure(cfg_val);
			pressure = (phase % 10 == 1);
			idle_mode <= pressure ? IDLE_NONE : idle_mode_t'(phase % 4);

			// load the edges in use: mostly falling tables, some dense, some scrambled;
			// big tables only get the entries that were never written
			style = $urandom_range(9);
			if (style < 7) begin
				stepmax = 32'hFFFF_FFFF / (used_n + 1);
				level = $urandom_range(32'hFFFF_FFFF, used_n * stepmax);
			end else begin
				stepmax = 3;
				level = $urandom_range(32'hFFFF_FFFF, 4 * (used_n + 1));
			end
			for (i = 0; i < used_n; i++) begin
				if (used_n <= 64 || !written[i])
					send_write(i, (style == 9) ? $urandom() : level);
				level = level - $urandom_range(stepmax, 1);
			end

			if (pressure)
				hold_requests <= hold_requests + 1;
			burst = (used_n > 64) ? 120 : $urandom_range(50, 20);
			repeat (burst) begin
				if (!pressure && $urandom_range(99) < 20) begin
					case ($urandom_range(7))
						0: level = '0;
						1: level = '1;
						default: level = $urandom();
					endcase
					send_write($urandom_range(TABLE_ENTRIES_DEF - 1), level);
				end else begin
					k = $urandom_range(used_n - 1);
					case ($urandom_range(9))
						0: probe = '0;
						1: probe = '1;
						2, 3, 4: probe = shadow_edges[k];
						5: probe = shadow_edges[k] + 1;
						6: probe = shadow_edges[k] - 1;
						7: probe = shadow_edges[used_n-1] - 1;
						8: probe = shadow_edges[0] + 1;
						default: probe = $urandom();
					endcase
					send_search(probe);
				end
			end
			phase++;
		end

		drain_results();
		if (failures == 0)
			$display("PASS energy_bin_search_top");
		else
			$display("FAIL energy_bin_search_top");
		$finish;
	end

endmodule
